>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// every macro samples on clk_i; the first one is held off while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define PSPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define PSPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/pspl_pkg.sv
// types and constants of the path point speed limiter
// used by the controller, the datapath and the top level
package pspl_pkg;

  localparam int unsigned CoordBits = 24;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned SpeedW    = 32;
  localparam int unsigned CfgIdxW   = 2;

  // squared distance scaled by 2^16, its root, and root * 25600
  localparam int unsigned RadW      = 2 * CoordBits + 18;
  localparam int unsigned RootW     = CoordBits + 9;
  localparam int unsigned RemW      = RootW + 3;
  localparam int unsigned NumW      = RootW + 15;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned DivSteps  = NumW;
  localparam int unsigned CntW      = $clog2(NumW);

  localparam logic [SpeedW-1:0] DefaultSpeed = 32'd65536;
  localparam logic [SpeedW-1:0] ManualReset  = 32'd65536;
  localparam logic [SpeedW-1:0] LimitReset   = 32'd131072;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE         = 2'd0,
    CFG_MANUAL_SPEED = 2'd1,
    CFG_SPEED_LIMIT  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_SCALE,
    ST_DIVIDE,
    ST_FINISH
  } pspl_state_e;

  typedef struct packed {
    logic                        first_point;
    logic [TimeW-1:0]            time_us;
    logic signed [CoordBits-1:0] pos_x;
    logic signed [CoordBits-1:0] pos_y;
    logic signed [CoordBits-1:0] pos_z;
  } pspl_in_t;

  typedef struct packed {
    logic [TimeW-1:0]            out_time_us;
    logic signed [CoordBits-1:0] out_x;
    logic signed [CoordBits-1:0] out_y;
    logic signed [CoordBits-1:0] out_z;
    logic [SpeedW-1:0]           point_speed;
    logic                        speed_limited;
  } pspl_out_t;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       rt_step;
    logic       scale;
    logic       dv_step;
    logic       out_load;
  } pspl_cmd_t;

  typedef struct packed {
    logic special;
  } pspl_stat_t;

endpackage

>>> hw/rtl/path_point_speed_limiter_core.sv
// path point speed: speed = |p - p_prev| * 256 * 25600 / dt, clamped to speed_limit
// computed points: squares of the three axes, the bit-serial square root, the scaling and the bit-serial
// divider run in turn; a new item is taken only once the last one has reached the output register
// manual mode, first point or non-increasing time: the square, root and divide steps are skipped
// the output register holds a result while the next item is taken and worked on
// async active-low reset: idle, output empty, config at reset values, previous point zero
module path_point_speed_limiter_core import pspl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [SpeedW-1:0]  cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pspl_in_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pspl_out_t          out_item_o
);

  pspl_cmd_t  cmd;
  pspl_stat_t stat;

  pspl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pspl_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_item_o (out_item_o)
  );

endmodule

>>> hw/rtl/pspl_datapath.sv
// datapath: config registers, previous point, squares, bit-serial root and divider
// depends on pspl_pkg; driven by pspl_ctrl commands
module pspl_datapath import pspl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [SpeedW-1:0]   cfg_data_i,
  input  pspl_in_t            in_item_i,
  input  pspl_cmd_t           cmd_i,
  output pspl_stat_t          stat_o,
  output pspl_out_t           out_item_o
);

  logic                 mode_q;
  logic [SpeedW-1:0]    manual_q, limit_q;
  logic [TimeW-1:0]     prev_time_q;
  logic [CoordBits-1:0] prev_x_q, prev_y_q, prev_z_q;

  logic [TimeW-1:0]     echo_time_q;
  logic [CoordBits-1:0] echo_x_q, echo_y_q, echo_z_q;
  logic                 special_q;
  logic [SpeedW-1:0]    spec_speed_q;
  logic                 spec_lim_q;
  logic [TimeW-1:0]     dt_q;
  logic [CoordBits-1:0] dx_q, dy_q, dz_q;
  logic [RadW-1:0]      rad_q;
  logic [RemW-1:0]      rem_q;
  logic [RootW-1:0]     root_q;
  logic [NumW-1:0]      num_q;
  logic [TimeW-1:0]     drem_q;
  pspl_out_t            out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      manual_q <= ManualReset;
      limit_q  <= LimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:         mode_q   <= cfg_data_i[0];
        CFG_MANUAL_SPEED: manual_q <= cfg_data_i;
        CFG_SPEED_LIMIT:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // absolute coordinate differences against the previous point
  function automatic logic [CoordBits-1:0] abs_diff(logic [CoordBits-1:0] a,
                                                    logic [CoordBits-1:0] b);
    logic [CoordBits:0] d;
    d = {a[CoordBits-1], a} - {b[CoordBits-1], b};
    if (d[CoordBits]) begin
      d = ~d + 1'b1;
    end
    return d[CoordBits-1:0];
  endfunction

  logic time_back;
  logic manual_over;
  assign time_back   = in_item_i.time_us <= prev_time_q;
  assign manual_over = manual_q > limit_q;

  // previous point follows every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_z_q    <= '0;
    end else if (cmd_i.load) begin
      prev_time_q <= in_item_i.time_us;
      prev_x_q    <= in_item_i.pos_x;
      prev_y_q    <= in_item_i.pos_y;
      prev_z_q    <= in_item_i.pos_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_q <= 1'b0;
    end else if (cmd_i.load) begin
      special_q <= mode_q | in_item_i.first_point | time_back;
    end
  end

  // square unit, one axis per cycle
  logic [CoordBits-1:0]   sq_in;
  logic [2*CoordBits-1:0] sq;
  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    sq_in = dx_q;
      2'd1:    sq_in = dy_q;
      default: sq_in = dz_q;
    endcase
  end
  assign sq = {{CoordBits{1'b0}}, sq_in} * {{CoordBits{1'b0}}, sq_in};

  // root digit: two radicand bits per step
  logic [RemW-1:0] rt_shift, rt_trial;
  logic            rt_fit;
  assign rt_shift = {rem_q[RemW-3:0], rad_q[RadW-1:RadW-2]};
  assign rt_trial = {1'b0, root_q, 2'b01};
  assign rt_fit   = rt_shift >= rt_trial;

  // divider digit: one quotient bit per step
  logic [TimeW:0] dv_shift;
  logic           dv_fit;
  assign dv_shift = {drem_q, num_q[NumW-1]};
  assign dv_fit   = dv_shift >= {1'b0, dt_q};

  // root * 25600 = (root * 25) << 10
  logic [NumW-1:0] root_ext, scaled;
  assign root_ext = NumW'(root_q);
  assign scaled   = ((root_ext << 4) + (root_ext << 3) + root_ext) << 10;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      echo_time_q <= in_item_i.time_us;
      echo_x_q    <= in_item_i.pos_x;
      echo_y_q    <= in_item_i.pos_y;
      echo_z_q    <= in_item_i.pos_z;
      dt_q        <= in_item_i.time_us - prev_time_q;
      dx_q        <= abs_diff(in_item_i.pos_x, prev_x_q);
      dy_q        <= abs_diff(in_item_i.pos_y, prev_y_q);
      dz_q        <= abs_diff(in_item_i.pos_z, prev_z_q);
      rad_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      drem_q      <= '0;
      if (mode_q) begin
        spec_speed_q <= manual_over ? limit_q : manual_q;
        spec_lim_q   <= manual_over;
      end else if (in_item_i.first_point) begin
        spec_speed_q <= DefaultSpeed;
        spec_lim_q   <= 1'b0;
      end else begin
        spec_speed_q <= limit_q;
        spec_lim_q   <= 1'b1;
      end
    end
    if (cmd_i.sq_en) begin
      rad_q <= rad_q + {2'b00, sq, 16'h0000};
    end
    if (cmd_i.rt_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= rt_fit ? rt_shift - rt_trial : rt_shift;
      root_q <= {root_q[RootW-2:0], rt_fit};
    end
    if (cmd_i.scale) begin
      num_q <= scaled;
    end
    if (cmd_i.dv_step) begin
      drem_q <= dv_fit ? TimeW'(dv_shift - {1'b0, dt_q}) : dv_shift[TimeW-1:0];
      num_q  <= {num_q[NumW-2:0], dv_fit};
    end
  end

  // clamp and output register
  logic calc_over;
  assign calc_over = num_q > NumW'(limit_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_time_us <= echo_time_q;
      out_q.out_x       <= echo_x_q;
      out_q.out_y       <= echo_y_q;
      out_q.out_z       <= echo_z_q;
      if (special_q) begin
        out_q.point_speed   <= spec_speed_q;
        out_q.speed_limited <= spec_lim_q;
      end else begin
        out_q.point_speed   <= calc_over ? limit_q : num_q[SpeedW-1:0];
        out_q.speed_limited <= calc_over;
      end
    end
  end

  assign stat_o.special = special_q;
  assign out_item_o     = out_q;

endmodule

>>> hw/rtl/pspl_ctrl.sv
// controller: sequences squares, root and divide steps, owns both handshakes
// depends on pspl_pkg and assert_macros.svh; commands pspl_datapath
`include "assert_macros.svh"

module pspl_ctrl import pspl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  pspl_stat_t stat_i,
  output pspl_cmd_t  cmd_o
);

  pspl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cnt_d      = '0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (stat_i.special) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.sq_en  = 1'b1;
          cmd_o.sq_sel = cnt_q[1:0];
          if (cnt_q == CntW'(2)) begin
            cnt_d   = '0;
            state_d = ST_ROOT;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_ROOT: begin
        cmd_o.rt_step = 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_SCALE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.dv_step = 1'b1;
        if (cnt_q == CntW'(DivSteps - 1)) begin
          cnt_d   = '0;
          state_d = ST_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `PSPL_ASSERT(a_load_needs_free_slot, cmd_o.out_load |-> (!out_valid_q || !out_stall_i), "result overwrites a waiting item")
  `PSPL_ASSERT(a_accept_starts_work, (in_valid_i && !in_stall_o) |=> (state_q == ST_SQUARE), "accepted item did not start work")
  `PSPL_ASSERT(a_root_count_bound, (state_q == ST_ROOT) |-> (cnt_q < CntW'(SqrtSteps)), "root step count overran")
  `PSPL_ASSERT(a_result_kept, (out_valid_q && out_stall_i) |=> out_valid_q, "stalled result dropped")
  `PSPL_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == ST_IDLE && !out_valid_q), "reset did not clear the controller")

endmodule

>>> tb/path_point_speed_limiter_core_tb.sv
// self-checking testbench for path_point_speed_limiter_core
// predicts each point's echo and speed from its own copy of the registers and the previous point
// depends on pspl_pkg and the core; directed cases first, then random paths under source idle and sink stall phases
module path_point_speed_limiter_core_tb;
  import pspl_pkg::*;

  localparam logic [63:0] SpeedScale = 64'd25600;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned DrainCycles = 100;
  localparam logic signed [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_MODE;
  logic [SpeedW-1:0]  cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  pspl_in_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  pspl_out_t          out_item_o;

  // predictor copy of the registers and of the previous point
  logic                        mdl_manual_mode = 1'b0;
  logic [SpeedW-1:0]           mdl_manual_speed = ManualReset;
  logic [SpeedW-1:0]           mdl_speed_limit = LimitReset;
  logic [TimeW-1:0]            last_time = '0;
  logic signed [CoordBits-1:0] last_x = '0;
  logic signed [CoordBits-1:0] last_y = '0;
  logic signed [CoordBits-1:0] last_z = '0;

  // current position of the random path walker
  logic [TimeW-1:0]            walk_time = '0;
  logic signed [CoordBits-1:0] walk_x = '0;
  logic signed [CoordBits-1:0] walk_y = '0;
  logic signed [CoordBits-1:0] walk_z = '0;

  pspl_out_t   pending_points[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;

  path_point_speed_limiter_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pspl_out_t predict_point(input pspl_in_t pt);
    pspl_out_t   res;
    longint      dx, dy, dz;
    logic [127:0] rad, cand_sq;
    logic [47:0] root, cand;
    logic [63:0] rate;
    res.out_time_us   = pt.time_us;
    res.out_x         = pt.pos_x;
    res.out_y         = pt.pos_y;
    res.out_z         = pt.pos_z;
    res.speed_limited = 1'b0;
    if (!mdl_manual_mode && pt.first_point) begin
      res.point_speed = DefaultSpeed;
    end else begin
      if (mdl_manual_mode) begin
        rate = 64'(mdl_manual_speed);
      end else if (pt.time_us <= last_time) begin
        // time stood still or went back: saturate
        rate = '1;
      end else begin
        dx = longint'(pt.pos_x) - longint'(last_x);
        dy = longint'(pt.pos_y) - longint'(last_y);
        dz = longint'(pt.pos_z) - longint'(last_z);
        rad = 128'(dx * dx + dy * dy + dz * dz) << 16;
        root = '0;
        for (int b = 47; b >= 0; b--) begin
          cand = root | (48'd1 << b);
          cand_sq = 128'(cand) * 128'(cand);
          if (cand_sq <= rad) begin
            root = cand;
          end
        end
        rate = (64'(root) * SpeedScale) / 64'(pt.time_us - last_time);
      end
      if (rate > 64'(mdl_speed_limit)) begin
        res.point_speed   = mdl_speed_limit;
        res.speed_limited = 1'b1;
      end else begin
        res.point_speed = rate[SpeedW-1:0];
      end
    end
    last_time = pt.time_us;
    last_x    = pt.pos_x;
    last_y    = pt.pos_y;
    last_z    = pt.pos_z;
    return res;
  endfunction

  function automatic pspl_in_t make_point(input logic first, input logic [TimeW-1:0] t,
                                          input logic signed [CoordBits-1:0] x, y, z);
    pspl_in_t pt;
    pt.first_point = first;
    pt.time_us     = t;
    pt.pos_x       = x;
    pt.pos_y       = y;
    pt.pos_z       = z;
    return pt;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic send_point(input pspl_in_t pt);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= pt;
    do @(posedge clk_i); while (in_stall_o);
    pending_points = {pending_points, predict_point(pt)};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SpeedW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_MODE:         mdl_manual_mode  = data[0];
      CFG_MANUAL_SPEED: mdl_manual_speed = data;
      CFG_SPEED_LIMIT:  mdl_speed_limit  = data;
      default: ;
    endcase
  endtask

  task automatic write_config(input logic mode, input logic [SpeedW-1:0] manual, limit);
    logic [SpeedW-1:0] mode_word;
    wait_drained();
    // upper bits of the mode word are don't-care
    mode_word = ($urandom() & ~32'd1) | SpeedW'(mode);
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_MANUAL_SPEED, manual);
    write_reg(CFG_SPEED_LIMIT, limit);
    write_reg(CfgIdxSpare, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  // reset config, previous point is still the all-zero reset point
  task automatic test_reset_state();
    send_point(make_point(1'b0, 32'd1000, 24'sd100, -24'sd200, 24'sd50));
    send_point(make_point(1'b1, 32'd2000, 24'sd7, 24'sd8, 24'sd9));
  endtask

  task automatic test_motion_extremes();
    write_config(1'b0, 32'd65536, '1);
    send_point(make_point(1'b1, 32'hFFFF_FFF0, CoordMax, CoordMax, CoordMax));
    send_point(make_point(1'b0, 32'hFFFF_FFFF, CoordMin, CoordMin, CoordMin));
    send_point(make_point(1'b0, 32'd0, '0, '0, '0));
    send_point(make_point(1'b0, 32'd0, '0, '0, '0));
    send_point(make_point(1'b0, 32'd1, '0, '0, '0));
    send_point(make_point(1'b0, 32'd1000001, 24'sd10000, '0, '0));
    send_point(make_point(1'b0, 32'd1500001, 24'sd12000, -24'sd3000, 24'sd777));
    write_config(1'b0, 32'd65536, '0);
    send_point(make_point(1'b0, 32'd2000001, 24'sd12000, -24'sd3000, 24'sd777));
    send_point(make_point(1'b0, 32'd2000002, 24'sd12001, -24'sd3000, 24'sd777));
    // first point keeps the default even above the limit
    send_point(make_point(1'b1, 32'd5, '0, '0, '0));
  endtask

  task automatic test_manual_speed();
    write_config(1'b1, '1, '1);
    send_point(make_point(1'b1, 32'd10, 24'sd5, 24'sd5, 24'sd5));
    send_point(make_point(1'b0, 32'd10, CoordMin, CoordMax, '0));
    write_config(1'b1, '1, '0);
    send_point(make_point(1'b0, 32'd3, '0, '0, '0));
    write_config(1'b1, '0, '0);
    send_point(make_point(1'b1, 32'd4, '0, '0, '0));
    write_config(1'b1, 32'd70000, 32'd65536);
    send_point(make_point(1'b0, 32'd10010, 24'sd15, 24'sd5, 24'sd5));
    // previous point was taken in manual mode
    write_config(1'b0, ManualReset, LimitReset);
    send_point(make_point(1'b0, 32'd20010, 24'sd45, 24'sd45, 24'sd5));
  endtask

  task automatic random_block(input int unsigned count);
    logic [SpeedW-1:0] limit, manual;
    pspl_in_t          pt;
    int unsigned       span;
    case ($urandom_range(5))
      0:       limit = '0;
      1:       limit = '1;
      2:       limit = $urandom();
      default: limit = $urandom_range(32'h0010_0000);
    endcase
    manual = $urandom_range(1) ? $urandom() : $urandom_range(32'h0004_0000);
    write_config($urandom_range(4) == 0, manual, limit);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) begin
        // noise: every field anywhere in its range
        pt.first_point = 1'($urandom_range(1));
        pt.time_us     = $urandom();
        pt.pos_x       = CoordBits'($urandom());
        pt.pos_y       = CoordBits'($urandom());
        pt.pos_z       = CoordBits'($urandom());
      end else if (i == 0 || $urandom_range(15) == 0) begin
        walk_time = $urandom();
        walk_x    = CoordBits'($urandom());
        walk_y    = CoordBits'($urandom());
        walk_z    = CoordBits'($urandom());
        pt = make_point(1'b1, walk_time, walk_x, walk_y, walk_z);
      end else begin
        // mostly forward in time, now and then a repeat or a step back
        case ($urandom_range(19))
          0:       ;
          1:       walk_time -= $urandom_range(1000);
          default: walk_time += $urandom_range(200000, 1);
        endcase
        span = 1 << (4 * $urandom_range(5, 1));
        walk_x += CoordBits'($urandom_range(2 * span) - span);
        walk_y += CoordBits'($urandom_range(2 * span) - span);
        walk_z += CoordBits'($urandom_range(2 * span) - span);
        pt = make_point(1'b0, walk_time, walk_x, walk_y, walk_z);
      end
      send_point(pt);
    end
  endtask

  task automatic test_random_paths();
    int unsigned idle_pcts [4] = '{0, 57, 0, 32};
    int unsigned stall_pcts [4] = '{0, 0, 57, 32};
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = idle_pcts[ph];
      snk_stall_pct = stall_pcts[ph];
      repeat (5) random_block(50);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_motion_extremes();
    test_manual_speed();
    test_random_paths();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("path_point_speed_limiter_core regression: pass");
    end else begin
      $display("path_point_speed_limiter_core regression: fail");
    end
    $finish;
  end

  // result checker, receiver stall and watchdog
  always @(posedge clk_i) begin
    pspl_out_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < snk_stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (pending_points.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, out_item_o);
          mismatch_count++;
        end else begin
          want = pending_points.pop_front();
          check_field("out_time_us", 64'(want.out_time_us), 64'(out_item_o.out_time_us));
          check_field("out_x", 64'(want.out_x), 64'(out_item_o.out_x));
          check_field("out_y", 64'(want.out_y), 64'(out_item_o.out_y));
          check_field("out_z", 64'(want.out_z), 64'(out_item_o.out_z));
          check_field("point_speed", 64'(want.point_speed), 64'(out_item_o.point_speed));
          check_field("speed_limited", 64'(want.speed_limited),
                      64'(out_item_o.speed_limited));
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no item moved in %0d cycles", $time, QuietLimit);
        $display("path_point_speed_limiter_core regression: fail");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/pspl_pkg.sv
hw/rtl/pspl_datapath.sv
hw/rtl/pspl_ctrl.sv
hw/rtl/path_point_speed_limiter_core.sv
tb/path_point_speed_limiter_core_tb.sv
